FILE: hw/rtl/gpp_pkg.sv
package gpp_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int COEF_FRAC  = 30;

    // Horner accumulator, Q.30 signed; the polynomial term stays below 2 in magnitude
    localparam int ACC_W   = COEF_FRAC + 4;
    localparam int SQ_W    = 2 * DATA_WIDTH - 1;
    localparam int PROD_W  = ACC_W + SQ_W + 1;
    // s = x*x in Q.24, so acc*s/2^(2*FRAC_BITS) stays in Q.30 like acc
    localparam int PROD_SHIFT = 2 * FRAC_BITS;
    localparam int SUM_W   = ACC_W + 2;
    localparam int OUT_SHIFT = COEF_FRAC - FRAC_BITS;
    localparam int HALF_SHIFT = COEF_FRAC - 1 - FRAC_BITS;
    localparam int RND_W   = SUM_W - OUT_SHIFT;
    localparam int N_CELLS = 6;

    localparam logic signed [DATA_WIDTH-1:0] THR =
        DATA_WIDTH'(7 * (1 << (FRAC_BITS - 1)));

    localparam logic signed [ACC_W-1:0] COEF_A0 = ACC_W'(242425);
    localparam logic signed [ACC_W-1:0] COEF_A7 = -ACC_W'(780);

    localparam logic [1:0] REGION_ZERO = 2'd0;
    localparam logic [1:0] REGION_POLY = 2'd1;
    localparam logic [1:0] REGION_IDENT = 2'd2;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic [SQ_W-1:0]              sq;
        logic signed [ACC_W-1:0]      acc;
    } gpp_stage_t;

    // Coefficient added by each cell: A6 down to A2, then none for the last multiply
    function automatic logic signed [ACC_W-1:0] cell_coef(input int idx);
        logic signed [ACC_W-1:0] c;
        begin
            unique case (idx)
                0:       c = ACC_W'(37540);
                1:       c = -ACC_W'(770765);
                2:       c = ACC_W'(9006994);
                3:       c = -ACC_W'(68401939);
                4:       c = ACC_W'(426147686);
                default: c = '0;
            endcase
            return c;
        end
    endfunction

endpackage

FILE: hw/rtl/gpp_in_if.sv
interface gpp_in_if;
    import gpp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] x_in;

    modport source (output valid, output x_in, input ready);
    modport sink (input valid, input x_in, output ready);
endinterface

FILE: hw/rtl/gpp_out_if.sv
interface gpp_out_if;
    import gpp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] y_out;
    logic [1:0]                   region;

    modport source (output valid, output y_out, output region, input ready);
    modport sink (input valid, input y_out, input region, output ready);
endinterface

FILE: hw/rtl/gpp_square.sv
module gpp_square (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_in,
    input  logic signed [gpp_pkg::DATA_WIDTH-1:0] x,
    output logic                                  ready_in,
    output logic                                  valid_out,
    output gpp_pkg::gpp_stage_t                   data_out,
    input  logic                                  ready_out
);
    import gpp_pkg::*;

    logic                        valid_reg;
    gpp_stage_t                  data_reg;
    gpp_stage_t                  data_next;
    logic signed [2*DATA_WIDTH-1:0] sq_full;

    assign ready_in = ~valid_reg | ready_out;
    assign sq_full  = x * x;

    always_comb
    begin
        data_next.x   = x;
        data_next.sq  = sq_full[SQ_W-1:0];
        data_next.acc = COEF_A7;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule

FILE: hw/rtl/gpp_cell.sv
module gpp_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [gpp_pkg::ACC_W-1:0] coef,
    input  logic                             valid_in,
    input  gpp_pkg::gpp_stage_t              data_in,
    output logic                             ready_in,
    output logic                             valid_out,
    output gpp_pkg::gpp_stage_t              data_out,
    input  logic                             ready_out
);
    import gpp_pkg::*;

    logic                       valid_reg;
    gpp_stage_t                 data_reg;
    gpp_stage_t                 data_next;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   prod_rnd;

    assign ready_in = ~valid_reg | ready_out;

    // One Horner step: acc = round(acc * s) + coef, ties toward plus infinity
    always_comb
    begin
        prod     = PROD_W'(data_in.acc) * $signed({1'b0, data_in.sq});
        prod_rnd = (prod + (PROD_W'(1) <<< (PROD_SHIFT - 1))) >>> PROD_SHIFT;
        data_next.x   = data_in.x;
        data_next.sq  = data_in.sq;
        data_next.acc = prod_rnd[ACC_W-1:0] + coef;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;
endmodule

FILE: hw/rtl/gpp_out.sv
module gpp_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    input  gpp_pkg::gpp_stage_t data_in,
    output logic                ready_in,
    gpp_out_if.source           result
);
    import gpp_pkg::*;

    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO = -SAT_HI - RND_W'(1);

    logic                         valid_reg;
    logic signed [DATA_WIDTH-1:0] y_reg;
    logic [1:0]                   region_reg;
    logic signed [DATA_WIDTH-1:0] y_next;
    logic [1:0]                   region_next;
    logic signed [SUM_W-1:0]      sum;
    logic signed [SUM_W-1:0]      sum_rnd;
    logic signed [RND_W-1:0]      rnd;
    logic signed [DATA_WIDTH-1:0] poly;

    assign ready_in = ~valid_reg | result.ready;

    always_comb
    begin
        sum = SUM_W'(data_in.acc) + SUM_W'(COEF_A0)
            + (SUM_W'(data_in.x) <<< HALF_SHIFT);
        sum_rnd = (sum + (SUM_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        rnd = sum_rnd[RND_W-1:0];
        if (rnd > SAT_HI)
            poly = SAT_HI[DATA_WIDTH-1:0];
        else if (rnd < SAT_LO)
            poly = SAT_LO[DATA_WIDTH-1:0];
        else
            poly = rnd[DATA_WIDTH-1:0];

        if (data_in.x < -THR)
        begin
            y_next      = '0;
            region_next = REGION_ZERO;
        end
        else if (data_in.x > THR)
        begin
            y_next      = data_in.x;
            region_next = REGION_IDENT;
        end
        else
        begin
            y_next      = poly;
            region_next = REGION_POLY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready_in)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_in && valid_in)
        begin
            y_reg      <= y_next;
            region_reg <= region_next;
        end
    end

    assign result.valid  = valid_reg;
    assign result.y_out  = y_reg;
    assign result.region = region_reg;
endmodule

FILE: hw/rtl/gelu_piecewise_poly.sv
// GELU activation, piecewise: zero below -3.5, identity above +3.5, and a
// degree-12 polynomial in between (x = -3.5 and x = +3.5 take the polynomial).
// Samples are signed Q4.12.
//
// Channels: sample (sink) carries x_in; result (source) carries y_out and
// region (0 zero, 1 polynomial, 2 identity). A request moves on a rising
// edge with valid and ready both high.
//
// One stage squares x, six cells each perform one Horner multiply-add
// in x squared, and one stage adds the linear term, rounds, saturates
// and selects the region. Throughput is one sample per cycle while the
// receiver does not stall, set by the one multiplier in each cell.
//
// Every stage holds its own valid bit. When the receiver stalls, the held
// result stays put while earlier stages keep filling empty slots, so up to
// eight requests are taken before sample.ready falls. Reset empties every
// stage; there is no other state.
module gelu_piecewise_poly (
    input  logic     clk,
    input  logic     rst_n,
    gpp_in_if.sink   sample,
    gpp_out_if.source result
);
    import gpp_pkg::*;

    logic       valid_c [N_CELLS+1];
    logic       ready_c [N_CELLS+1];
    gpp_stage_t data_c  [N_CELLS+1];

    gpp_square u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sample.valid),
        .x         (sample.x_in),
        .ready_in  (sample.ready),
        .valid_out (valid_c[0]),
        .data_out  (data_c[0]),
        .ready_out (ready_c[0])
    );

    for (genvar i = 0; i < N_CELLS; i++)
    begin : g_cell
        gpp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      (cell_coef(i)),
            .valid_in  (valid_c[i]),
            .data_in   (data_c[i]),
            .ready_in  (ready_c[i]),
            .valid_out (valid_c[i+1]),
            .data_out  (data_c[i+1]),
            .ready_out (ready_c[i+1])
        );
    end

    gpp_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (valid_c[N_CELLS]),
        .data_in  (data_c[N_CELLS]),
        .ready_in (ready_c[N_CELLS]),
        .result   (result)
    );
endmodule
